// ----- hw/rtl/comment_marker_stripper_unit_assert.svh -----
// ----------------------------------------------------------------------------
// comment_marker_stripper_unit_assert.svh
// Assertion macros for the comment marker stripper. Each use expects clk and
// rst in scope. Defining ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef COMMENT_MARKER_STRIPPER_UNIT_ASSERT_SVH
`define COMMENT_MARKER_STRIPPER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CMS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CMS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define CMS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/cms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_pkg
// Types, character codes and the marker scan shared by the stripper modules.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // queue between front and back, power of two
  localparam int QDEPTH = 2;
  localparam int QPTW   = $clog2(QDEPTH);

  localparam logic [1:0] ACT_WAIT = 2'd0;
  localparam logic [1:0] ACT_DROP = 2'd1;
  localparam logic [1:0] ACT_PASS = 2'd2;

  localparam logic [1:0] LK_NO   = 2'd0;
  localparam logic [1:0] LK_YES  = 2'd1;
  localparam logic [1:0] LK_WAIT = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_valid;
    logic       in_last;
  } cms_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_end;
    logic       out_changed;
  } cms_out_t;

  typedef struct packed {
    logic [1:0] act;
    logic [2:0] take;
  } cms_dec_t;

  // results of one item: up to four kept bytes, then an end item if fin
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            fin;
    logic            chg;
  } cms_bundle_t;

  typedef struct packed {
    logic [3:0][7:0] outs;
    logic [2:0]      cnt;
    logic [2:0][7:0] held;
    logic [1:0]      held_cnt;
    logic            rem;
  } cms_scan_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cms_qstat_t;

  function automatic logic [1:0] cms_look(input logic [3:0][7:0] w, input logic [2:0] m,
                                          input logic fin, input logic [1:0] i,
                                          input logic [7:0] c);
    logic [1:0] r;
    if ({1'b0, i} >= m) r = fin ? LK_NO : LK_WAIT;
    else r = (w[i] == c) ? LK_YES : LK_NO;
    return r;
  endfunction

  // what to do with the head byte of window w, which holds m bytes
  function automatic cms_dec_t cms_decide(input logic [3:0][7:0] w, input logic [2:0] m,
                                          input logic fin);
    cms_dec_t   d;
    logic [7:0] h;
    logic [1:0] r1;
    logic [1:0] r2;
    logic [1:0] r3;
    h      = w[0];
    d.act  = ACT_PASS;
    d.take = 3'd1;
    r1     = LK_NO;
    r2     = LK_NO;
    r3     = LK_NO;
    if (h == CH_SLASH || h == CH_STAR) begin
      r1 = cms_look(w, m, fin, 2'd1, (h == CH_SLASH) ? CH_STAR : CH_SLASH);
      if (r1 == LK_WAIT) d.act = ACT_WAIT;
      else if (r1 == LK_YES) begin
        d.act  = ACT_DROP;
        d.take = 3'd2;
      end
    end else if (h == CH_LT) begin
      r1 = cms_look(w, m, fin, 2'd1, CH_BANG);
      r2 = cms_look(w, m, fin, 2'd2, CH_DASH);
      r3 = cms_look(w, m, fin, 2'd3, CH_DASH);
      if (r1 == LK_WAIT) d.act = ACT_WAIT;
      else if (r1 == LK_NO) d.act = ACT_PASS;
      else if (r2 == LK_WAIT) d.act = ACT_WAIT;
      else if (r2 == LK_NO) d.act = ACT_PASS;
      else if (r3 == LK_WAIT) d.act = ACT_WAIT;
      else if (r3 == LK_NO) d.act = ACT_PASS;
      else begin
        d.act  = ACT_DROP;
        d.take = 3'd4;
      end
    end else if (h == CH_DASH) begin
      r1 = cms_look(w, m, fin, 2'd1, CH_DASH);
      r2 = cms_look(w, m, fin, 2'd2, CH_GT);
      if (r1 == LK_WAIT) d.act = ACT_WAIT;
      else if (r1 == LK_NO) d.act = ACT_PASS;
      else if (r2 == LK_WAIT) d.act = ACT_WAIT;
      else begin
        d.act  = ACT_DROP;
        d.take = (r2 == LK_YES) ? 3'd3 : 3'd2;
      end
    end else if (h == CH_HASH) begin
      d.act = ACT_DROP;
    end
    return d;
  endfunction

  // greedy scan over up to four bytes; whatever is still undecided is held
  function automatic cms_scan_t cms_scan(input logic [3:0][7:0] buff, input logic [2:0] n,
                                         input logic fin);
    cms_scan_t   s;
    cms_dec_t    d;
    logic [2:0]  pos;
    logic [2:0]  m;
    logic [2:0]  tk;
    logic        done;
    logic [31:0] w;
    s    = '0;
    pos  = 3'd0;
    done = 1'b0;
    for (int it = 0; it < 4; it++) begin
      if (!done && pos < n) begin
        w = buff >> {pos[1:0], 3'b000};
        m = n - pos;
        d = cms_decide(w, m, fin);
        if (d.act == ACT_WAIT) begin
          done = 1'b1;
        end else begin
          tk = (d.take > m) ? m : d.take;
          if (d.act == ACT_PASS) begin
            s.outs[s.cnt[1:0]] = w[7:0];
            s.cnt = s.cnt + 3'd1;
          end else begin
            s.rem = 1'b1;
          end
          pos = pos + tk;
        end
      end
    end
    w          = buff >> {pos[1:0], 3'b000};
    m          = n - pos;
    s.held     = w[23:0];
    s.held_cnt = m[1:0];
    return s;
  endfunction

endpackage

// ----- hw/rtl/cms_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_front
// Takes input items, scans held bytes plus the new byte for markers and
// pushes the kept bytes of each item to the queue as one bundle.
// ----------------------------------------------------------------------------
module cms_front (
  input  logic                 clk,
  input  logic                 rst,
  input  cms_pkg::cms_in_t     text,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  cms_pkg::cms_qstat_t  q_stat,
  output logic                 push,
  output cms_pkg::cms_bundle_t push_data
);
  import cms_pkg::*;

  logic [2:0][7:0] held;
  logic [1:0]      held_count;
  logic            removed_any;
  logic [3:0][7:0] buff;
  logic [2:0]      n;
  logic            accept;
  cms_scan_t       scan;

  always_comb begin
    buff = {8'h00, held};
    if (text.in_valid) buff[held_count] = text.in_byte;
    n    = {1'b0, held_count} + {2'b00, text.in_valid};
    scan = cms_scan(buff, n, text.in_last);
  end

  assign text_stall = q_stat.full;
  assign accept     = text_valid && !text_stall;
  // idle items and items that only add lookahead give nothing to the queue
  assign push       = accept && (scan.cnt != 3'd0 || text.in_last);

  assign push_data.bytes = scan.outs;
  assign push_data.cnt   = scan.cnt;
  assign push_data.fin   = text.in_last;
  assign push_data.chg   = removed_any | scan.rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count  <= 2'd0;
      removed_any <= 1'b0;
    end else if (accept) begin
      if (text.in_last) begin
        held_count  <= 2'd0;
        removed_any <= 1'b0;
      end else begin
        held_count  <= scan.held_cnt;
        removed_any <= removed_any | scan.rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held <= scan.held;
  end

endmodule

// ----- hw/rtl/cms_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_queue
// Short FIFO of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
module cms_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cms_pkg::cms_bundle_t push_data,
  input  logic                 pop,
  output cms_pkg::cms_bundle_t head,
  output cms_pkg::cms_qstat_t  q_stat
);
  import cms_pkg::*;

  localparam logic [QPTW:0] QFULL = (QPTW + 1)'(QDEPTH);

  cms_bundle_t     slots [QDEPTH];
  logic [QPTW-1:0] wr_ptr;
  logic [QPTW-1:0] rd_ptr;
  logic [QPTW:0]   level;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (level == QFULL);
  assign q_stat.empty = (level == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        2'b11:   level <= level;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// ----- hw/rtl/cms_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_back
// Unpacks the head bundle into result items, one a cycle while the output is
// not stalled, into the output register.
// ----------------------------------------------------------------------------
module cms_back (
  input  logic                 clk,
  input  logic                 rst,
  input  cms_pkg::cms_bundle_t head,
  input  cms_pkg::cms_qstat_t  q_stat,
  output logic                 pop,
  output cms_pkg::cms_out_t    res,
  output logic                 res_valid,
  input  logic                 res_stall
);
  import cms_pkg::*;

  logic [2:0] idx;
  logic [2:0] total;
  logic       load;
  logic       last;
  cms_out_t   cur;

  assign total = head.cnt + {2'b00, head.fin};
  assign load  = !q_stat.empty && (!res_valid || !res_stall);
  assign last  = (idx + 3'd1 == total);
  assign pop   = load && last;

  always_comb begin
    if (idx < head.cnt) begin
      cur.out_byte    = head.bytes[idx[1:0]];
      cur.out_valid   = 1'b1;
      cur.out_end     = 1'b0;
      cur.out_changed = 1'b0;
    end else begin
      // end item follows the kept bytes
      cur.out_byte    = 8'h00;
      cur.out_valid   = 1'b0;
      cur.out_end     = 1'b1;
      cur.out_changed = head.chg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      if (load) idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= cur;
  end

endmodule

// ----- hw/rtl/comment_marker_stripper_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_marker_stripper_unit
// Removes comment delimiters and every '#' from a byte stream, then reports
// whether anything was removed on a closing end item.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   text     | text_valid / text_stall | cms_in_t  (byte, valid, last)
//   res      | res_valid / res_stall   | cms_out_t (byte, valid, end, chg)
//
// One input item a cycle while the bundle queue is not full; the marker scan in the front is combinational.
// The back unpacks result items one by one; an item with several results
// (up to five at the end of a string) keeps its bundle at the queue head until the last is loaded.
// Input stalls only while the two-entry bundle queue is full.
// Synchronous reset clears lookahead count, removal flag, queue and output valid flag.
// ----------------------------------------------------------------------------
`include "comment_marker_stripper_unit_assert.svh"

module comment_marker_stripper_unit (
  input  logic              clk,
  input  logic              rst,
  input  cms_pkg::cms_in_t  text,
  input  logic              text_valid,
  output logic              text_stall,
  output cms_pkg::cms_out_t res,
  output logic              res_valid,
  input  logic              res_stall
);
  import cms_pkg::*;

  cms_qstat_t  q_stat;
  cms_bundle_t push_data;
  cms_bundle_t head;
  logic        push;
  logic        pop;

  cms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  cms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .res       (res),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

  `CMS_ASSERT_IMPLY(a_push_not_full, push, !q_stat.full, "bundle pushed into a full queue")
  `CMS_ASSERT_IMPLY(a_pop_not_empty, pop, !q_stat.empty, "bundle popped from an empty queue")
  `CMS_ASSERT_NEXT(a_push_fills, push, !q_stat.empty, "queue empty after a push")
  `CMS_ASSERT_IMPLY(a_end_no_byte, res_valid && res.out_end,
                    !res.out_valid && res.out_byte == 8'h00, "end item carries a byte")

endmodule

// ----- test/tb_comment_marker_stripper_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_comment_marker_stripper_unit
// Self-checking bench for the comment marker stripper. Byte strings, mostly
// built from marker fragments, go into the text channel under varying sender
// idling and receiver stalling. A scoreboard runs its own greedy marker scan
// on each accepted item and checks every result item, field by field, in
// order.
// ----------------------------------------------------------------------------
module tb_comment_marker_stripper_unit;
  import cms_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 120;

  typedef enum logic [1:0] {SEEN_NO, SEEN_YES, SEEN_LATER} peek_t;
  typedef enum logic [1:0] {DEC_HOLD, DEC_DROP, DEC_KEEP} dec_t;

  class strip_scoreboard;
    logic [7:0] held[$];
    bit         removed;
    cms_out_t   expected_q[$];
    int         errors;

    function peek_t peek(int idx, logic [7:0] c, bit fin);
      if (idx >= held.size()) return fin ? SEEN_NO : SEEN_LATER;
      return (held[idx] == c) ? SEEN_YES : SEEN_NO;
    endfunction

    // decision on the head byte; take is the number of bytes it consumes
    function dec_t classify(bit fin, output int take);
      logic [7:0] h;
      peek_t      p;
      h    = held[0];
      take = 1;
      if (h == CH_SLASH || h == CH_STAR) begin
        p = peek(1, (h == CH_SLASH) ? CH_STAR : CH_SLASH, fin);
        if (p == SEEN_LATER) return DEC_HOLD;
        if (p == SEEN_NO) return DEC_KEEP;
        take = 2;
        return DEC_DROP;
      end
      if (h == CH_LT) begin
        p = peek(1, CH_BANG, fin);
        if (p == SEEN_LATER) return DEC_HOLD;
        if (p == SEEN_NO) return DEC_KEEP;
        p = peek(2, CH_DASH, fin);
        if (p == SEEN_LATER) return DEC_HOLD;
        if (p == SEEN_NO) return DEC_KEEP;
        p = peek(3, CH_DASH, fin);
        if (p == SEEN_LATER) return DEC_HOLD;
        if (p == SEEN_NO) return DEC_KEEP;
        take = 4;
        return DEC_DROP;
      end
      if (h == CH_DASH) begin
        p = peek(1, CH_DASH, fin);
        if (p == SEEN_LATER) return DEC_HOLD;
        if (p == SEEN_NO) return DEC_KEEP;
        p = peek(2, CH_GT, fin);
        if (p == SEEN_LATER) return DEC_HOLD;
        take = (p == SEEN_YES) ? 3 : 2;
        return DEC_DROP;
      end
      if (h == CH_HASH) return DEC_DROP;
      return DEC_KEEP;
    endfunction

    function void note_text(cms_in_t it);
      dec_t     d;
      int       take;
      cms_out_t r;
      if (it.in_valid) held.push_back(it.in_byte);
      while (held.size() > 0) begin
        d = classify(it.in_last, take);
        if (d == DEC_HOLD) break;
        if (take > held.size()) take = held.size();
        if (d == DEC_KEEP) begin
          r           = '0;
          r.out_byte  = held[0];
          r.out_valid = 1'b1;
          expected_q.push_back(r);
        end else begin
          removed = 1'b1;
        end
        repeat (take) void'(held.pop_front());
      end
      if (it.in_last) begin
        r             = '0;
        r.out_end     = 1'b1;
        r.out_changed = removed;
        expected_q.push_back(r);
        held.delete();
        removed = 1'b0;
      end
    endfunction

    function void check_res(cms_out_t got);
      cms_out_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.out_byte !== exp_r.out_byte) begin
        $error("out_byte: expected %h, got %h", exp_r.out_byte, got.out_byte);
        errors++;
      end
      if (got.out_valid !== exp_r.out_valid) begin
        $error("out_valid: expected %b, got %b", exp_r.out_valid, got.out_valid);
        errors++;
      end
      if (got.out_end !== exp_r.out_end) begin
        $error("out_end: expected %b, got %b", exp_r.out_end, got.out_end);
        errors++;
      end
      if (got.out_changed !== exp_r.out_changed) begin
        $error("out_changed: expected %b, got %b", exp_r.out_changed, got.out_changed);
        errors++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  cms_in_t  text = '0;
  logic     text_valid = 1'b0;
  logic     text_stall;
  cms_out_t res;
  logic     res_valid;
  logic     res_stall = 1'b0;

  int idle_pct  = 0;
  int stall_pct = 0;
  int n_sent    = 0;
  int quiet     = 0;

  strip_scoreboard sb;

  wire text_acc = text_valid && !text_stall;
  wire res_acc  = res_valid && !res_stall;

  comment_marker_stripper_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .res        (res),
    .res_valid  (res_valid),
    .res_stall  (res_stall)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // results checked before the same edge's input is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (res_acc) sb.check_res(res);
      if (text_acc) sb.note_text(text);
    end
  end

  always @(posedge clk) begin
    if (rst || text_acc || res_acc) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input cms_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text       <= it;
    text_valid <= 1'b1;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    @(negedge clk);
    if (it.in_valid || it.in_last) n_sent++;
  endtask

  // ignored items dropped in at random between bytes
  task automatic send_string(input logic [7:0] s[$], input bit end_alone);
    cms_in_t it;
    for (int i = 0; i < s.size(); i++) begin
      if ($urandom_range(19) == 0) begin
        it         = '0;
        it.in_byte = 8'($urandom_range(255));
        send_item(it);
      end
      it.in_byte  = s[i];
      it.in_valid = 1'b1;
      it.in_last  = !end_alone && (i == s.size() - 1);
      send_item(it);
    end
    if (end_alone || s.size() == 0) begin
      it          = '0;
      it.in_byte  = 8'($urandom_range(255));
      it.in_last  = 1'b1;
      send_item(it);
    end
  endtask

  task automatic send_text(input string t, input bit end_alone);
    logic [7:0] s[$];
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_string(s, end_alone);
  endtask

  function automatic void add_token(ref logic [7:0] s[$]);
    logic [7:0] marks[7];
    marks = '{CH_SLASH, CH_STAR, CH_LT, CH_BANG, CH_DASH, CH_GT, CH_HASH};
    case ($urandom_range(11))
      0: begin s.push_back(CH_SLASH); s.push_back(CH_STAR); end
      1: begin s.push_back(CH_STAR); s.push_back(CH_SLASH); end
      2: begin
        s.push_back(CH_LT); s.push_back(CH_BANG);
        s.push_back(CH_DASH); s.push_back(CH_DASH);
      end
      3: begin s.push_back(CH_DASH); s.push_back(CH_DASH); s.push_back(CH_GT); end
      4: begin s.push_back(CH_DASH); s.push_back(CH_DASH); end
      5: s.push_back(CH_HASH);
      6: begin s.push_back(CH_LT); s.push_back(CH_BANG); s.push_back(CH_DASH); end
      7: begin s.push_back(CH_LT); s.push_back(CH_BANG); end
      8: s.push_back(CH_DASH);
      9: s.push_back(8'($urandom_range(255)));
      10: s.push_back(8'($urandom_range(8'h61, 8'h7A)));
      default: s.push_back(marks[$urandom_range(6)]);
    endcase
  endfunction

  task automatic random_string();
    logic [7:0] s[$];
    int         n;
    if ($urandom_range(9) == 0) begin
      // noise: plain random bytes
      n = $urandom_range(8, 1);
      repeat (n) s.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(6);
      repeat (n) add_token(s);
    end
    send_string(s, $urandom_range(1) == 1);
  endtask

  initial begin
    cms_in_t    it;
    logic [7:0] s[$];
    int         idle_set[4];
    int         stall_set[4];
    sb        = new();
    idle_set  = '{0, 67, 0, 33};
    stall_set = '{0, 0, 67, 33};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed strings
    send_text("", 1'b1);
    send_text("/**/-->", 1'b0);
    send_text("<!--", 1'b1);
    send_text("a--", 1'b0);
    send_text("<!-x", 1'b0);
    it         = '0;
    it.in_byte = CH_HASH;
    it.in_valid = 1'b1;
    send_item(it);
    it          = '0;
    it.in_byte  = 8'hFF;
    send_item(it);
    it.in_last  = 1'b1;
    send_item(it);
    s = '{8'h00, 8'hFF};
    send_string(s, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      while (n_sent < 24 + (ph + 1) * ITEMS_PER_PHASE) random_string();
    end
    text_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/cms_pkg.sv
hw/rtl/cms_front.sv
hw/rtl/cms_queue.sv
hw/rtl/cms_back.sv
hw/rtl/comment_marker_stripper_unit.sv
test/tb_comment_marker_stripper_unit.sv
